// ----- hw/rtl/maze_shortest_path_search_defines.svh -----
// ----------------------------------------------------------------------------
// Maze search assertion macros
// Shared concurrent assertion shorthands for the maze search RTL.
// ----------------------------------------------------------------------------
`ifndef MAZE_SHORTEST_PATH_SEARCH_DEFINES_SVH
`define MAZE_SHORTEST_PATH_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mss_pkg.sv -----
// ----------------------------------------------------------------------------
// Maze search package
// Field widths, cell kinds, controller states, datapath commands and status.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int IDX_W   = 6;
  localparam int COORD_W = 3;
  localparam int KIND_W  = 2;
  localparam int DIST_W  = 6;

  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WALL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TARGET = 2'd2;

  localparam logic [1:0] DIR_DOWN  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  typedef enum logic {
    OPC_LOAD  = 1'b0,
    OPC_START = 1'b1
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START_CHK,
    S_SEED_RD,
    S_SEED_CHK,
    S_POP,
    S_POP_Q,
    S_POP_D,
    S_NB,
    S_NB_CHK,
    S_W_NB,
    S_W_CHK,
    S_W_DONE,
    S_EMIT
  } ctl_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_START_CHK,
    OP_SEED_RD,
    OP_SEED_CHK,
    OP_POP_RD,
    OP_POP_Q,
    OP_POP_D,
    OP_NB,
    OP_NB_CHK,
    OP_W_INIT,
    OP_W_NB,
    OP_W_CHK,
    OP_W_DONE,
    OP_EMIT_TGT,
    OP_W_NEXT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic start_oob;
    logic start_tgt;
    logic scan_last;
    logic q_empty;
    logic nb_ok;
    logic wnb_ok;
    logic dir_last;
    logic pick_zero;
    logic out_last;
  } dp_status_t;

  typedef struct packed {
    logic               ok;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } nb_t;

  // Neighbor of (row, col) in direction dir on a side x side grid.
  function automatic nb_t nb_of(input logic [COORD_W-1:0] row,
                                input logic [COORD_W-1:0] col,
                                input logic [1:0] dir,
                                input logic [3:0] side);
    nb_t n;
    n.row = row;
    n.col = col;
    n.ok  = 1'b0;
    unique case (dir)
      DIR_DOWN: begin
        n.ok  = (4'(row) + 4'd1) < side;
        n.row = row + 3'd1;
      end
      DIR_RIGHT: begin
        n.ok  = (4'(col) + 4'd1) < side;
        n.col = col + 3'd1;
      end
      DIR_UP: begin
        n.ok  = row != '0;
        n.row = row - 3'd1;
      end
      DIR_LEFT: begin
        n.ok  = col != '0;
        n.col = col - 3'd1;
      end
    endcase
    return n;
  endfunction

endpackage

// ----- hw/rtl/mss_in_if.sv -----
// ----------------------------------------------------------------------------
// Maze search request channel
// Valid/ready channel carrying load and start requests.
// ----------------------------------------------------------------------------
interface mss_in_if import mss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [IDX_W-1:0]   cell_index;
  logic [KIND_W-1:0]  cell_kind;
  logic [COORD_W-1:0] start_row;
  logic [COORD_W-1:0] start_col;

  modport source (output valid, opcode, cell_index, cell_kind, start_row, start_col,
                  input ready);
  modport sink (input valid, opcode, cell_index, cell_kind, start_row, start_col,
                output ready);
endinterface

// ----- hw/rtl/mss_out_if.sv -----
// ----------------------------------------------------------------------------
// Maze search result channel
// Valid/ready channel carrying path steps.
// ----------------------------------------------------------------------------
interface mss_out_if import mss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] step_cell;
  logic             last_step;

  modport source (output valid, found, step_cell, last_step, input ready);
  modport sink (input valid, found, step_cell, last_step, output ready);
endinterface

// ----- hw/rtl/mss_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/mss_datapath.sv -----
// ----------------------------------------------------------------------------
// Maze search datapath
// Grid, distance and queue RAMs, visit flags, walk and output registers.
// ----------------------------------------------------------------------------
module mss_datapath import mss_pkg::*; #(
  parameter int SIDE = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_status_t         st,
  input  logic [IDX_W-1:0]   in_cell_index,
  input  logic [KIND_W-1:0]  in_cell_kind,
  input  logic [COORD_W-1:0] in_start_row,
  input  logic [COORD_W-1:0] in_start_col,
  output logic               out_found,
  output logic [IDX_W-1:0]   out_step_cell,
  output logic               out_last_step
);
  localparam int NCELL = SIDE * SIDE;
  localparam int AW    = $clog2(NCELL);
  localparam int CNT_W = $clog2(NCELL + 1);
  localparam logic [3:0] SIDE_V = 4'(SIDE);
  localparam logic [COORD_W-1:0] LAST_C = COORD_W'(SIDE - 1);

  function automatic logic [IDX_W-1:0] idx_of(input logic [COORD_W-1:0] r,
                                               input logic [COORD_W-1:0] c);
    return IDX_W'(32'(r) * SIDE + 32'(c));
  endfunction

  logic [COORD_W-1:0] s_row_r, s_col_r, cur_row_r, cur_col_r;
  logic [COORD_W-1:0] pick_row_r, pick_col_r;
  logic [1:0]         dir_r;
  logic [CNT_W-1:0]   head_r, tail_r;
  logic [DIST_W-1:0]  dc_r, best_r;
  logic               pick_v_r;
  logic               out_found_r, out_last_r;
  logic [IDX_W-1:0]   out_cell_r;

  nb_t                  nb;
  logic [IDX_W-1:0]     nb_idx, cur_idx, s_idx;
  logic                 s_is_nb, seed_hit, enter, new_cell;
  logic [KIND_W-1:0]    grid_rd;
  logic [DIST_W:0]      dist_rd;
  logic                 vis_rd;
  logic [DIST_W-1:0]    dist_val;
  logic [2*COORD_W-1:0] q_rd;
  logic                 grid_we, q_we, dist_we;
  logic [IDX_W-1:0]     grid_ra, dist_ra, dist_wa;
  logic [DIST_W:0]      dist_wd;
  logic [2*COORD_W-1:0] q_wd;

  assign nb      = nb_of(cur_row_r, cur_col_r, dir_r, SIDE_V);
  assign nb_idx  = idx_of(nb.row, nb.col);
  assign cur_idx = idx_of(cur_row_r, cur_col_r);
  assign s_idx   = idx_of(s_row_r, s_col_r);
  assign s_is_nb = (nb.row == s_row_r) && (nb.col == s_col_r);
  assign seed_hit = (grid_rd == KIND_TARGET) &&
                    !((cur_row_r == s_row_r) && (cur_col_r == s_col_r));
  assign enter   = (grid_rd == KIND_EMPTY) || (grid_rd == KIND_TARGET);
  // distance RAM word: visit flag on top, distance below
  assign vis_rd   = dist_rd[DIST_W];
  assign dist_val = dist_rd[DIST_W-1:0];
  assign new_cell = enter && !vis_rd;

  assign st.start_oob = (32'(in_start_row) >= SIDE) || (32'(in_start_col) >= SIDE);
  assign st.start_tgt = grid_rd == KIND_TARGET;
  assign st.scan_last = (cur_row_r == LAST_C) && (cur_col_r == LAST_C);
  assign st.q_empty   = head_r == tail_r;
  assign st.nb_ok     = nb.ok && !s_is_nb;
  assign st.wnb_ok    = nb.ok;
  assign st.dir_last  = dir_r == DIR_LEFT;
  assign st.pick_zero = best_r == '0;
  assign st.out_last  = out_last_r;

  assign grid_we = (cmd.op == OP_LOAD) && (32'(in_cell_index) < NCELL);

  always_comb begin
    unique case (cmd.op)
      OP_START: grid_ra = idx_of(in_start_row, in_start_col);
      OP_NB:    grid_ra = nb_idx;
      default:  grid_ra = cur_idx;
    endcase
    if (cmd.op == OP_POP_Q) begin
      dist_ra = idx_of(q_rd[2*COORD_W-1:COORD_W], q_rd[COORD_W-1:0]);
    end else begin
      dist_ra = nb_idx;
    end
    // the seed scan rewrites every cell, clearing stale visit flags and marking targets visited
    dist_we = (cmd.op == OP_SEED_CHK) || ((cmd.op == OP_NB_CHK) && new_cell);
    q_we    = ((cmd.op == OP_SEED_CHK) && seed_hit) || ((cmd.op == OP_NB_CHK) && new_cell);
    if (cmd.op == OP_SEED_CHK) begin
      dist_wa = cur_idx;
      dist_wd = {seed_hit, DIST_W'(0)};
      q_wd    = {cur_row_r, cur_col_r};
    end else begin
      dist_wa = nb_idx;
      dist_wd = {1'b1, dc_r + DIST_W'(1)};
      q_wd    = {nb.row, nb.col};
    end
  end

  mss_ram #(.WIDTH(KIND_W), .DEPTH(NCELL)) u_grid (
    .clk(clk), .we(grid_we), .waddr(in_cell_index[AW-1:0]), .wdata(in_cell_kind),
    .raddr(grid_ra[AW-1:0]), .rdata(grid_rd)
  );

  mss_ram #(.WIDTH(DIST_W + 1), .DEPTH(NCELL)) u_dist (
    .clk(clk), .we(dist_we), .waddr(dist_wa[AW-1:0]), .wdata(dist_wd),
    .raddr(dist_ra[AW-1:0]), .rdata(dist_rd)
  );

  mss_ram #(.WIDTH(2*COORD_W), .DEPTH(NCELL)) u_queue (
    .clk(clk), .we(q_we), .waddr(tail_r[AW-1:0]), .wdata(q_wd),
    .raddr(head_r[AW-1:0]), .rdata(q_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      dir_r      <= '0;
      pick_v_r   <= 1'b0;
      out_last_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_START: begin
          s_row_r   <= in_start_row;
          s_col_r   <= in_start_col;
          if (st.start_oob) begin
            out_found_r <= 1'b0;
            out_cell_r  <= '0;
            out_last_r  <= 1'b1;
          end
        end
        OP_START_CHK: begin
          if (st.start_tgt) begin
            out_found_r <= 1'b1;
            out_cell_r  <= s_idx;
            out_last_r  <= 1'b1;
          end
          cur_row_r <= '0;
          cur_col_r <= '0;
          head_r    <= '0;
          tail_r    <= '0;
        end
        OP_SEED_CHK: begin
          if (seed_hit) begin
            tail_r <= tail_r + CNT_W'(1);
          end
          if (cur_col_r == LAST_C) begin
            cur_col_r <= '0;
            cur_row_r <= cur_row_r + 3'd1;
          end else begin
            cur_col_r <= cur_col_r + 3'd1;
          end
        end
        OP_POP_RD: head_r <= head_r + CNT_W'(1);
        OP_POP_Q: begin
          cur_row_r <= q_rd[2*COORD_W-1:COORD_W];
          cur_col_r <= q_rd[COORD_W-1:0];
        end
        OP_POP_D: begin
          dc_r  <= dist_val;
          dir_r <= '0;
        end
        OP_NB: begin
          if (!st.nb_ok) begin
            dir_r <= dir_r + 2'd1;
          end
        end
        OP_NB_CHK: begin
          if (new_cell) begin
            tail_r <= tail_r + CNT_W'(1);
          end
          dir_r <= dir_r + 2'd1;
        end
        OP_W_INIT: begin
          cur_row_r <= s_row_r;
          cur_col_r <= s_col_r;
          dir_r     <= '0;
          pick_v_r  <= 1'b0;
        end
        OP_W_NB: begin
          if (!st.wnb_ok) begin
            dir_r <= dir_r + 2'd1;
          end
        end
        OP_W_CHK: begin
          // strict compare keeps the first neighbor on a tie
          if (vis_rd && (!pick_v_r || (dist_val < best_r))) begin
            pick_v_r   <= 1'b1;
            best_r     <= dist_val;
            pick_row_r <= nb.row;
            pick_col_r <= nb.col;
          end
          dir_r <= dir_r + 2'd1;
        end
        OP_W_DONE: begin
          if (!pick_v_r) begin
            out_found_r <= 1'b0;
            out_cell_r  <= '0;
            out_last_r  <= 1'b1;
          end else begin
            out_found_r <= 1'b1;
            out_cell_r  <= cur_idx;
            out_last_r  <= 1'b0;
            cur_row_r   <= pick_row_r;
            cur_col_r   <= pick_col_r;
          end
        end
        OP_EMIT_TGT: begin
          out_cell_r <= cur_idx;
          out_last_r <= 1'b1;
        end
        OP_W_NEXT: begin
          dir_r    <= '0;
          pick_v_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign out_found     = out_found_r;
  assign out_step_cell = out_cell_r;
  assign out_last_step = out_last_r;
endmodule

// ----- hw/rtl/mss_ctrl.sv -----
// ----------------------------------------------------------------------------
// Maze search controller
// Sequences loading, target seeding, BFS expansion, path walk and output.
// ----------------------------------------------------------------------------
`include "maze_shortest_path_search_defines.svh"

module mss_ctrl import mss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_opcode,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t st
);
  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OPC_START) begin
            cmd.op    = OP_START;
            state_nxt = st.start_oob ? S_EMIT : S_START_CHK;
          end else begin
            cmd.op = OP_LOAD;
          end
        end
      end
      S_START_CHK: begin
        cmd.op    = OP_START_CHK;
        state_nxt = st.start_tgt ? S_EMIT : S_SEED_RD;
      end
      S_SEED_RD: begin
        cmd.op    = OP_SEED_RD;
        state_nxt = S_SEED_CHK;
      end
      S_SEED_CHK: begin
        cmd.op    = OP_SEED_CHK;
        state_nxt = st.scan_last ? S_POP : S_SEED_RD;
      end
      S_POP: begin
        if (st.q_empty) begin
          cmd.op    = OP_W_INIT;
          state_nxt = S_W_NB;
        end else begin
          cmd.op    = OP_POP_RD;
          state_nxt = S_POP_Q;
        end
      end
      S_POP_Q: begin
        cmd.op    = OP_POP_Q;
        state_nxt = S_POP_D;
      end
      S_POP_D: begin
        cmd.op    = OP_POP_D;
        state_nxt = S_NB;
      end
      S_NB: begin
        cmd.op = OP_NB;
        if (st.nb_ok) begin
          state_nxt = S_NB_CHK;
        end else begin
          state_nxt = st.dir_last ? S_POP : S_NB;
        end
      end
      S_NB_CHK: begin
        cmd.op    = OP_NB_CHK;
        state_nxt = st.dir_last ? S_POP : S_NB;
      end
      S_W_NB: begin
        cmd.op = OP_W_NB;
        if (st.wnb_ok) begin
          state_nxt = S_W_CHK;
        end else begin
          state_nxt = st.dir_last ? S_W_DONE : S_W_NB;
        end
      end
      S_W_CHK: begin
        cmd.op    = OP_W_CHK;
        state_nxt = st.dir_last ? S_W_DONE : S_W_NB;
      end
      S_W_DONE: begin
        cmd.op    = OP_W_DONE;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          priority if (st.out_last) begin
            state_nxt = S_IDLE;
          end else if (st.pick_zero) begin
            cmd.op = OP_EMIT_TGT;
          end else begin
            cmd.op    = OP_W_NEXT;
            state_nxt = S_W_NB;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = state_r == S_EMIT;

  `MSS_ASSERT_NOW(a_one_side_busy, in_ready, !out_valid, "request taken while result pending")
  `MSS_ASSERT_NEXT(a_last_ends_run, out_valid && out_ready && st.out_last, in_ready,
    "run did not end after last step")
  `MSS_ASSERT_NEXT(a_start_busy, in_valid && in_ready && (in_opcode == OPC_START),
    !in_ready, "start request did not begin a search")
endmodule

// ----- hw/rtl/maze_shortest_path_search.sv -----
// Shortest-path maze search on a SIDE x SIDE grid. Load requests (opcode 0) write one
// cell kind each; out-of-range indices are dropped. A start request (opcode 1) returns
// the path from the start cell to the nearest target, one result per cell, last_step
// set on the target, tie-broken down, right, up, left; with no path it returns a single
// result with found cleared. A search first scans every cell to seed targets (this scan
// also clears the visit flags of all other cells), then runs a distance pass over the
// reachable cells, then walks the path subject to output backpressure; the grid,
// distance and queue RAMs have registered reads.
// No new request is taken until the last result of a search has been delivered.
// ----------------------------------------------------------------------------
// Maze shortest path search, top level
// Joins the controller and datapath to the request and result channels.
// ----------------------------------------------------------------------------
module maze_shortest_path_search import mss_pkg::*; #(
  parameter int SIDE = 7
) (
  input logic       clk,
  input logic       rst_n,
  mss_in_if.sink    in_if,
  mss_out_if.source out_if
);
  dp_cmd_t    cmd;
  dp_status_t st;

  mss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_opcode (in_if.opcode),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .st        (st)
  );

  mss_datapath #(.SIDE(SIDE)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_cell_index (in_if.cell_index),
    .in_cell_kind  (in_if.cell_kind),
    .in_start_row  (in_if.start_row),
    .in_start_col  (in_if.start_col),
    .out_found     (out_if.found),
    .out_step_cell (out_if.step_cell),
    .out_last_step (out_if.last_step)
  );
endmodule
